// ===== sv/drt_pkg.sv =====
// Shared types, constants and helpers for the detection run event tracker.
// No dependencies; imported by every module of the block.
package drt_pkg;

	localparam int CNT_W   = 8;
	localparam int RUN_W   = 10;
	localparam int FRM_W   = 10;
	localparam int SUM_W   = 32;
	localparam int MARG_W  = 8;
	localparam int OUT_W   = 120;
	localparam int ADDR_W  = 5;
	localparam int COUNT_BITS_DEF = 8;

	localparam logic [1:0] OP_PRIMARY = 2'd0;
	localparam logic [1:0] OP_NESTED  = 2'd1;
	localparam logic [1:0] OP_FRAME   = 2'd2;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_START = 2'd1;
	localparam logic [1:0] EV_STOP  = 2'd2;

	localparam logic [2:0] REG_WINDOW    = 3'd0;
	localparam logic [2:0] REG_WARMUP    = 3'd1;
	localparam logic [2:0] REG_MARGIN    = 3'd2;
	localparam logic [2:0] REG_RUN_THR   = 3'd3;
	localparam logic [2:0] REG_ABOVE_THR = 3'd4;
	localparam logic [2:0] REG_NESTED_EN = 3'd5;

	typedef struct packed {
		logic [FRM_W-1:0]  window_frames;
		logic [FRM_W-1:0]  warmup_frames;
		logic [MARG_W-1:0] above_margin;
		logic [RUN_W-1:0]  run_threshold;
		logic [RUN_W-1:0]  above_run_threshold;
		logic              nested_enabled;
	} cfg_t;

	typedef struct packed {
		logic [5:0]       pad;
		logic [RUN_W-1:0] nested_above_run;
		logic [CNT_W-1:0] nested_last;
		logic [SUM_W-1:0] nested_average;
		logic [RUN_W-1:0] nested_run;
		logic [CNT_W-1:0] primary_last;
		logic [SUM_W-1:0] primary_average;
		logic [RUN_W-1:0] primary_run;
		logic [1:0]       nested_event;
		logic [1:0]       primary_event;
	} res_t;

	function automatic logic [RUN_W-1:0] inc_sat(input logic [RUN_W-1:0] v);
		inc_sat = (v == {RUN_W{1'b1}}) ? v : v + RUN_W'(1);
	endfunction

endpackage

// ===== sv/drt_cfg.sv =====
// APB register file holding the tracker settings.
// Depends on drt_pkg.
module drt_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [drt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output drt_pkg::cfg_t              cfg
);
	import drt_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_frames       <= FRM_W'(500);
			cfg_q.warmup_frames       <= FRM_W'(60);
			cfg_q.above_margin        <= MARG_W'(10);
			cfg_q.run_threshold       <= RUN_W'(20);
			cfg_q.above_run_threshold <= RUN_W'(5);
			cfg_q.nested_enabled      <= 1'b1;
		end else if (wr) begin
			case (idx)
				REG_WINDOW:    cfg_q.window_frames       <= pwdata[FRM_W-1:0];
				REG_WARMUP:    cfg_q.warmup_frames       <= pwdata[FRM_W-1:0];
				REG_MARGIN:    cfg_q.above_margin        <= pwdata[MARG_W-1:0];
				REG_RUN_THR:   cfg_q.run_threshold       <= pwdata[RUN_W-1:0];
				REG_ABOVE_THR: cfg_q.above_run_threshold <= pwdata[RUN_W-1:0];
				REG_NESTED_EN: cfg_q.nested_enabled      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_WINDOW:    prdata = 32'(cfg_q.window_frames);
			REG_WARMUP:    prdata = 32'(cfg_q.warmup_frames);
			REG_MARGIN:    prdata = 32'(cfg_q.above_margin);
			REG_RUN_THR:   prdata = 32'(cfg_q.run_threshold);
			REG_ABOVE_THR: prdata = 32'(cfg_q.above_run_threshold);
			REG_NESTED_EN: prdata = 32'(cfg_q.nested_enabled);
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== sv/drt_div.sv =====
// Restoring divider, one quotient bit per cycle, sum by frame count.
// Depends on drt_pkg.
module drt_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [drt_pkg::SUM_W-1:0] dividend,
	input  logic [drt_pkg::FRM_W-1:0] divisor,
	output logic                      done,
	output logic [drt_pkg::SUM_W-1:0] quotient
);
	import drt_pkg::*;

	localparam int CW = $clog2(SUM_W);

	logic [SUM_W-1:0] quo_q;
	logic [FRM_W-1:0] rem_q;
	logic [FRM_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [FRM_W:0]   shifted;
	logic [FRM_W:0]   diff;
	logic             ge;

	assign shifted  = {rem_q, quo_q[SUM_W-1]};
	assign ge       = shifted >= {1'b0, dvs_q};
	assign diff     = shifted - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(SUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[FRM_W-1:0] : shifted[FRM_W-1:0];
		end
	end

endmodule

// ===== sv/detection_run_event_tracker.sv =====
// Top level: two count trackers, end-of-frame event logic and sequencer.
// Depends on drt_pkg, drt_cfg and drt_div.
//
// channel  | dir | handshake            | payload
// s_       | in  | s_tvalid / s_tready  | s_tuser operation, s_tdata count
// m_       | out | m_tvalid / m_tready  | m_tdata result fields
// apb      | in  | psel, penable, pready| paddr, pwdata, prdata
//
// A sample request raises m_tvalid once the 32-step serial divider that forms
// the average has finished; the next request is accepted only after the
// result has been loaded. End of frame, ignored codes and disabled nested
// samples skip the division before raising m_tvalid.
// Reset clears all tracker state and event flags. A stalled result holds
// the block in its final state until taken.
module detection_run_event_tracker #(
	parameter int COUNT_BITS = drt_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] count
	input  logic [1:0]                 s_tuser,   // [1:0] operation
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [1:0] primary_event, [3:2] nested_event, [13:4] primary_run,
	// [45:14] primary_average, [53:46] primary_last, [63:54] nested_run,
	// [95:64] nested_average, [103:96] nested_last, [113:104] nested_above_run
	output logic [drt_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [drt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import drt_pkg::*;

	localparam int CntUse = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
	localparam logic [CNT_W-1:0] CntMask = CNT_W'((33'd1 << CntUse) - 33'd1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	cfg_t cfg;

	logic [1:0]       state_q;
	logic [1:0]       op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       pev_q, nev_q;
	res_t             res_q;
	logic             mvalid_q;

	logic [CNT_W-1:0] last_q [2];
	logic [RUN_W-1:0] run_q  [2];
	logic [RUN_W-1:0] abv_q  [2];
	logic [SUM_W-1:0] sum_q  [2];
	logic [FRM_W-1:0] frm_q  [2];
	logic [SUM_W-1:0] avg_q  [2];
	logic             act_q  [2];

	logic             t;
	logic             smp;
	logic             clr;
	logic [CNT_W-1:0] l0, n_last;
	logic [RUN_W-1:0] r0, ab0, n_run, n_abv;
	logic [SUM_W-1:0] s0, a0, n_sum;
	logic [FRM_W-1:0] f0, n_frm;
	logic             above;
	logic             p_on;
	logic             n_on;
	logic [1:0]       pev_d, nev_d;
	logic             act0_d, act1_d;
	logic             res_load;

	logic             div_start;
	logic             div_done;
	logic [SUM_W-1:0] div_quo;

	drt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	drt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_sum),
		.divisor  (n_frm),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = res_q;

	assign t   = op_q[0];
	assign smp = (op_q == OP_PRIMARY) || ((op_q == OP_NESTED) && cfg.nested_enabled);
	assign div_start = (state_q == ST_EXEC) && smp;
	assign res_load  = (state_q == ST_DONE) && (!mvalid_q || m_tready);

	// sample update ahead of the division
	always_comb begin
		clr   = frm_q[t] >= cfg.window_frames;
		f0    = clr ? '0 : frm_q[t];
		l0    = clr ? '0 : last_q[t];
		r0    = clr ? '0 : run_q[t];
		ab0   = clr ? '0 : abv_q[t];
		s0    = clr ? '0 : sum_q[t];
		a0    = clr ? '0 : avg_q[t];
		above = 33'(l0) > (33'(a0) + 33'(cfg.above_margin));
		n_abv = ab0;
		if (f0 >= cfg.warmup_frames) begin
			n_abv = above ? inc_sat(ab0) : '0;
		end
		if (cnt_q != '0) begin
			n_run  = inc_sat(r0);
			n_last = cnt_q;
			n_sum  = s0 + SUM_W'(cnt_q);
			n_frm  = inc_sat(f0);
		end else begin
			n_run  = '0;
			n_last = l0;
			n_sum  = s0;
			n_frm  = FRM_W'(1);
		end
	end

	assign p_on = run_q[0] > cfg.run_threshold;
	assign n_on = (run_q[1] > cfg.run_threshold) && (SUM_W'(last_q[1]) > avg_q[1]) &&
		(abv_q[1] > cfg.above_run_threshold);

	// end-of-frame events
	always_comb begin
		pev_d  = EV_NONE;
		nev_d  = EV_NONE;
		act0_d = act_q[0];
		act1_d = act_q[1];
		if (p_on) begin
			if (!act_q[0]) begin
				act0_d = 1'b1;
				pev_d  = EV_START;
			end
		end else begin
			if (act_q[0]) begin
				pev_d = EV_STOP;
			end
			act0_d = 1'b0;
		end
		if (cfg.nested_enabled && p_on) begin
			if (n_on) begin
				if (!act_q[1]) begin
					act1_d = 1'b1;
					nev_d  = EV_START;
				end
			end else if (abv_q[1] == '0) begin
				if (act_q[1]) begin
					nev_d = EV_STOP;
				end
				act1_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (res_load) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pev_q    <= EV_NONE;
			nev_q    <= EV_NONE;
			op_q     <= OP_PRIMARY;
			cnt_q    <= '0;
			for (int i = 0; i < 2; i++) begin
				last_q[i] <= '0;
				run_q[i]  <= '0;
				abv_q[i]  <= '0;
				sum_q[i]  <= '0;
				frm_q[i]  <= '0;
				avg_q[i]  <= '0;
				act_q[i]  <= 1'b0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						cnt_q   <= s_tdata & CntMask;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (smp) begin
						pev_q     <= EV_NONE;
						nev_q     <= EV_NONE;
						last_q[t] <= n_last;
						run_q[t]  <= n_run;
						abv_q[t]  <= n_abv;
						sum_q[t]  <= n_sum;
						frm_q[t]  <= n_frm;
						state_q   <= ST_DIV;
					end else if (op_q == OP_FRAME) begin
						pev_q    <= pev_d;
						nev_q    <= nev_d;
						act_q[0] <= act0_d;
						act_q[1] <= act1_d;
						state_q  <= ST_DONE;
					end else begin
						pev_q   <= EV_NONE;
						nev_q   <= EV_NONE;
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						avg_q[t] <= div_quo;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.pad              <= '0;
			res_q.primary_event    <= pev_q;
			res_q.nested_event     <= nev_q;
			res_q.primary_run      <= run_q[0];
			res_q.primary_average  <= avg_q[0];
			res_q.primary_last     <= last_q[0];
			res_q.nested_run       <= run_q[1];
			res_q.nested_average   <= avg_q[1];
			res_q.nested_last      <= last_q[1];
			res_q.nested_above_run <= abv_q[1];
		end
	end

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mvalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised without completing a request");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		mvalid_q |-> (res_q.primary_event == EV_NONE || res_q.primary_event == EV_START ||
			res_q.primary_event == EV_STOP) && (res_q.nested_event == EV_NONE ||
			res_q.nested_event == EV_START || res_q.nested_event == EV_STOP))
		else $error("undefined event code in result");

endmodule
